// ===== src/thfd_pkg.sv =====
// Package for the tagged-header frame deframer.
// Holds header tags, window size, mode and item codes; no dependencies.
package thfd_pkg;

    localparam int unsigned HDR_BYTES = 20;
    localparam int unsigned FILL_W    = 5;

    localparam logic [31:0] START_TAG = 32'hffff_ffff;
    localparam logic [31:0] END_TAG   = 32'hfefe_fefe;

    localparam logic MODE_HUNT = 1'b0;
    localparam logic MODE_BODY = 1'b1;

    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_ABORT = 1'b1;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_BODY   = 1'b1;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [31:0] content_check;
        logic [31:0] header_check;
        logic [31:0] frame_length;
        logic [7:0]  body_byte;
    } out_data_t;

endpackage

// ===== src/tagged_header_frame_deframer_top.sv =====
// Tagged-header frame deframer, top level.
// Depends on thfd_pkg.
//
// channel  | dir | tdata                    | tuser  | tlast
// ---------+-----+--------------------------+--------+-----------
// s_       | in  | rx_byte                  | action | -
// m_       | out | body_byte, frame_length, | kind   | frame_last
//          |     | header_check, content_ck |        |
//
// One word per clock while s_tready is high; the header match and body count resolve in the
// cycle the word is taken, result lands in the output register.
// s_tready is high whenever the output register is empty or being drained.
// rst_n clears the mode, window fill, byte count and output valid.
module tagged_header_frame_deframer_top
    import thfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    input  logic         s_tuser,   // [0] action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // [7:0] body_byte, [39:8] frame_length,
                                    // [71:40] header_check, [103:72] content_check
    output logic         m_tuser,   // [0] kind
    output logic         m_tlast    // frame_last
);

    logic                mode_reg, mode_next;
    byte_t               win_reg [HDR_BYTES];
    byte_t               win_next [HDR_BYTES];
    byte_t               win_shift [HDR_BYTES];
    logic [FILL_W-1:0]   fill_reg, fill_next, fill_inc;
    logic [31:0]         remain_reg, remain_next, remain_dec;

    logic                m_valid_reg, m_valid_next;
    out_data_t           m_data_reg, m_data_next;
    logic                m_kind_reg, m_kind_next;
    logic                m_last_reg, m_last_next;

    logic                accept;
    logic                match;
    logic [31:0]         w_start, w_hchk, w_len, w_cchk, w_end;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        for (int i = 0; i < HDR_BYTES - 1; i++)
        begin
            win_shift[i] = win_reg[i + 1];
        end
        win_shift[HDR_BYTES - 1] = s_tdata;
    end

    assign w_start = {win_shift[3],  win_shift[2],  win_shift[1],  win_shift[0]};
    assign w_hchk  = {win_shift[7],  win_shift[6],  win_shift[5],  win_shift[4]};
    assign w_len   = {win_shift[11], win_shift[10], win_shift[9],  win_shift[8]};
    assign w_cchk  = {win_shift[15], win_shift[14], win_shift[13], win_shift[12]};
    assign w_end   = {win_shift[19], win_shift[18], win_shift[17], win_shift[16]};

    assign fill_inc   = (fill_reg < FILL_W'(HDR_BYTES)) ? fill_reg + 1'b1 : fill_reg;
    assign match      = (fill_inc == FILL_W'(HDR_BYTES)) && (w_start == START_TAG)
                        && (w_end == END_TAG);
    assign remain_dec = (remain_reg != 32'd0) ? remain_reg - 32'd1 : remain_reg;

    always_comb
    begin
        mode_next    = mode_reg;
        win_next     = win_reg;
        fill_next    = fill_reg;
        remain_next  = remain_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_kind_next  = m_kind_reg;
        m_last_next  = m_last_reg;

        if (accept)
        begin
            if (s_tuser == ACT_ABORT)
            begin
                mode_next   = MODE_HUNT;
                fill_next   = '0;
                remain_next = '0;
                for (int i = 0; i < HDR_BYTES; i++)
                begin
                    win_next[i] = '0;
                end
            end
            else if (mode_reg == MODE_BODY)
            begin
                m_valid_next = 1'b1;
                m_kind_next  = KIND_BODY;
                m_data_next  = '{content_check: '0, header_check: '0,
                                 frame_length: '0, body_byte: s_tdata};
                m_last_next  = (remain_dec == 32'd0);
                remain_next  = remain_dec;
                if (remain_dec == 32'd0)
                begin
                    mode_next = MODE_HUNT;
                    fill_next = '0;
                    for (int i = 0; i < HDR_BYTES; i++)
                    begin
                        win_next[i] = '0;
                    end
                end
            end
            else if (match)
            begin
                m_valid_next = 1'b1;
                m_kind_next  = KIND_HEADER;
                m_data_next  = '{content_check: w_cchk, header_check: w_hchk,
                                 frame_length: w_len, body_byte: '0};
                m_last_next  = (w_len == 32'd0);
                fill_next    = '0;
                remain_next  = w_len;
                mode_next    = (w_len == 32'd0) ? MODE_HUNT : MODE_BODY;
                for (int i = 0; i < HDR_BYTES; i++)
                begin
                    win_next[i] = '0;
                end
            end
            else
            begin
                win_next  = win_shift;
                fill_next = fill_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_HUNT;
            fill_reg    <= '0;
            remain_reg  <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < HDR_BYTES; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            mode_reg    <= mode_next;
            fill_reg    <= fill_next;
            remain_reg  <= remain_next;
            m_valid_reg <= m_valid_next;
            win_reg     <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_kind_reg <= m_kind_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule
